@@ design/pik_pkg.sv @@
// shared constants, types and the arctangent table for the planar arm solver
`timescale 1ns / 1ps
package pik_pkg;

  localparam int LINK_ONE_LEN = 5820;
  localparam int LINK_TWO_LEN = 5735;
  localparam int RETREAT_STEP = 26;
  localparam int CORDIC_ITERS = 16;

  localparam int POS_MIN = 2560;
  localparam int POS_MAX = 10240;
  localparam int X_FLOOR = 256;
  localparam int Y_FLOOR = 1280;

  localparam int REACH_FAR  = (LINK_ONE_LEN + LINK_TWO_LEN) * (LINK_ONE_LEN + LINK_TWO_LEN);
  localparam int REACH_NEAR = (LINK_ONE_LEN - LINK_TWO_LEN) * (LINK_ONE_LEN - LINK_TWO_LEN);
  localparam int L_SQ_SUM   = LINK_ONE_LEN * LINK_ONE_LEN + LINK_TWO_LEN * LINK_TWO_LEN;
  localparam int L_SQ_DIFF  = LINK_ONE_LEN * LINK_ONE_LEN - LINK_TWO_LEN * LINK_TWO_LEN;
  localparam int FOUR_L1_SQ = 4 * LINK_ONE_LEN * LINK_ONE_LEN;
  localparam longint DEN_E    = 2 * longint'(LINK_ONE_LEN) * longint'(LINK_TWO_LEN);
  localparam longint DEN_E_SQ = DEN_E * DEN_E;
  localparam longint PI_Q24   = 52707179;

  localparam int MUL_W  = 34;
  localparam int PROD_W = 2 * MUL_W;
  localparam int SQ_W   = 56;  // must be even
  localparam int ROOT_W = SQ_W / 2;
  localparam int ANG_W  = 32;
  localparam int ACC_W  = 44;

  localparam logic [1:0] REG_W_SHOULDER = 2'd0;
  localparam logic [1:0] REG_W_ELBOW    = 2'd1;
  localparam logic [1:0] REG_W_WRIST    = 2'd2;

  typedef struct packed {
    logic busy;
    logic done;
  } pik_stat_t;

  // arctan(2^-i) in 2^-24 rad
  function automatic logic signed [ANG_W-1:0] atan_step(input int i);
    logic signed [ANG_W-1:0] r;
    case (i)
      0: r = 32'sd13176795;
      1: r = 32'sd7778716;
      2: r = 32'sd4110060;
      3: r = 32'sd2086331;
      4: r = 32'sd1047214;
      5: r = 32'sd524117;
      6: r = 32'sd262123;
      7: r = 32'sd131069;
      default: r = (i <= 24) ? ANG_W'(32'sd1 <<< (24 - i)) : '0;
    endcase
    return r;
  endfunction

endpackage

@@ design/pik_mul.sv @@
// shared signed multiplier with registered product
`timescale 1ns / 1ps
module pik_mul (
  input  logic                              clk_i,
  input  logic signed [pik_pkg::MUL_W-1:0]  a_i,
  input  logic signed [pik_pkg::MUL_W-1:0]  b_i,
  output logic signed [pik_pkg::PROD_W-1:0] p_o
);
  import pik_pkg::*;

  always_ff @(posedge clk_i) begin
    p_o <= PROD_W'(a_i) * PROD_W'(b_i);
  end

endmodule

@@ design/pik_isqrt.sv @@
// bit-serial floor square root, one result bit per cycle
`timescale 1ns / 1ps
module pik_isqrt (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start_i,
  input  logic [pik_pkg::SQ_W-1:0]         v_i,
  output logic [pik_pkg::ROOT_W-1:0]       root_o,
  output pik_pkg::pik_stat_t               stat_o
);
  import pik_pkg::*;

  typedef enum logic {S_IDLE, S_RUN} state_e;

  state_e          state_q;
  logic            done_q;
  logic [SQ_W-1:0] v_q, r_q, b_q;
  logic [SQ_W:0]   sum;
  logic            ge;
  logic [SQ_W-1:0] r_nx, v_nx;

  always_comb begin
    sum  = {1'b0, r_q} + {1'b0, b_q};
    ge   = {1'b0, v_q} >= sum;
    r_nx = ge ? (r_q >> 1) + b_q : r_q >> 1;
    v_nx = ge ? v_q - sum[SQ_W-1:0] : v_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      done_q  <= 1'b0;
    end else begin
      done_q <= 1'b0;
      case (state_q)
        S_IDLE: begin
          if (start_i) begin
            v_q     <= v_i;
            r_q     <= '0;
            b_q     <= SQ_W'(1) << (SQ_W - 2);
            state_q <= S_RUN;
          end
        end
        S_RUN: begin
          v_q <= v_nx;
          r_q <= r_nx;
          b_q <= b_q >> 2;
          if (b_q[0]) begin
            root_o  <= r_nx[ROOT_W-1:0];
            done_q  <= 1'b1;
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign stat_o.busy = (state_q != S_IDLE);
  assign stat_o.done = done_q;

endmodule

@@ design/pik_cordic.sv @@
// iterative vectoring cordic atan2, result in 2^-24 rad
`timescale 1ns / 1ps
module pik_cordic (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start_i,
  input  logic signed [pik_pkg::ANG_W-1:0] x_i,
  input  logic signed [pik_pkg::ANG_W-1:0] y_i,
  output logic signed [pik_pkg::ANG_W-1:0] z_o,
  output pik_pkg::pik_stat_t               stat_o
);
  import pik_pkg::*;

  localparam int CW   = ANG_W + 3;
  localparam int IT_W = $clog2(CORDIC_ITERS + 1);
  localparam logic signed [CW-1:0] NORM_HI = CW'(1) <<< 30;
  localparam logic signed [CW-1:0] NORM_LO = CW'(1) <<< 29;

  typedef enum logic [1:0] {C_IDLE, C_NORM, C_ITER, C_FIN} state_e;

  state_e                  state_q;
  logic                    done_q;
  logic signed [CW-1:0]    cx_q, cy_q;
  logic signed [ANG_W-1:0] z_q;
  logic                    neg_x_q, neg_y_q, zero_q;
  logic [IT_W-1:0]         it_q;
  logic signed [CW-1:0]    ax, ay, sh_x, sh_y;
  logic signed [ANG_W-1:0] z_fin;

  always_comb begin
    ax    = x_i[ANG_W-1] ? -CW'(x_i) : CW'(x_i);
    ay    = y_i[ANG_W-1] ? -CW'(y_i) : CW'(y_i);
    sh_x  = cx_q >>> it_q;
    sh_y  = cy_q >>> it_q;
    z_fin = z_q;
    if (neg_x_q) z_fin = ANG_W'(PI_Q24) - z_fin;
    if (neg_y_q) z_fin = -z_fin;
    if (zero_q)  z_fin = '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= C_IDLE;
      done_q  <= 1'b0;
    end else begin
      done_q <= 1'b0;
      case (state_q)
        C_IDLE: begin
          if (start_i) begin
            cx_q    <= ax;
            cy_q    <= ay;
            neg_x_q <= x_i[ANG_W-1];
            neg_y_q <= y_i[ANG_W-1];
            zero_q  <= (ax == '0) && (ay == '0);
            z_q     <= '0;
            it_q    <= '0;
            state_q <= ((ax == '0) && (ay == '0)) ? C_FIN : C_NORM;
          end
        end
        C_NORM: begin
          if (cx_q >= NORM_HI || cy_q >= NORM_HI) begin
            cx_q <= cx_q >>> 1;
            cy_q <= cy_q >>> 1;
          end else if (cx_q < NORM_LO && cy_q < NORM_LO) begin
            cx_q <= cx_q <<< 1;
            cy_q <= cy_q <<< 1;
          end else begin
            state_q <= C_ITER;
          end
        end
        C_ITER: begin
          if (cy_q >= 0) begin
            cx_q <= cx_q + sh_y;
            cy_q <= cy_q - sh_x;
            z_q  <= z_q + atan_step(int'(it_q));
          end else begin
            cx_q <= cx_q - sh_y;
            cy_q <= cy_q + sh_x;
            z_q  <= z_q - atan_step(int'(it_q));
          end
          it_q <= it_q + 1'b1;
          if (it_q == IT_W'(CORDIC_ITERS - 1)) state_q <= C_FIN;
        end
        C_FIN: begin
          z_o     <= z_fin;
          done_q  <= 1'b1;
          state_q <= C_IDLE;
        end
        default: state_q <= C_IDLE;
      endcase
    end
  end

  assign stat_o.busy = (state_q != C_IDLE);
  assign stat_o.done = done_q;

endmodule

@@ design/planar_arm_inverse_kinematics.sv @@
// top level: sequencer for retreat, two-link solve and nearest-solution pick
// sequence: for a reachable target, three cordic runs, two square roots and a six-term
//   weighted cost pass; a far target first retreats in the reach loop, each step
//   squaring the moved coordinate and checking the reach again
// throughput: one transaction at a time, set by the shared multiplier and cordic
// reset: weights 154/77/26, angles 125, -125, 0 degrees and yaw 95 degrees
`timescale 1ns / 1ps
module planar_arm_inverse_kinematics (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_idx_i,
  input  logic [7:0]         cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic signed [15:0] target_x_i,
  input  logic signed [15:0] target_y_i,
  input  logic signed [15:0] target_yaw_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic               solved_o,
  output logic               retreated_o,
  output logic signed [15:0] shoulder_out_o,
  output logic signed [15:0] elbow_out_o,
  output logic signed [15:0] wrist_out_o,
  output logic signed [15:0] yaw_out_o
);
  import pik_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE, S_SQX, S_LDX, S_SQY, S_LDY, S_CHK, S_E0, S_E1, S_E2, S_E3, S_B0,
    S_T1, S_T2, S_T3, S_T4, S_C0, S_K_SQ, S_K_WT, S_K_ACC, S_SEL, S_FIN
  } state_e;

  typedef enum logic [1:0] {PH_FIRST, PH_XLOOP, PH_YLOOP, PH_SECOND} phase_e;

  state_e state_q;
  phase_e ph_q;

  logic [7:0] w_sh_q, w_el_q, w_wr_q;
  logic signed [15:0] shoulder_q, elbow_q, wrist_q, yaw_st_q;
  logic signed [15:0] x_q, y_q, yaw_q;
  logic [26:0] xsq_q, ysq_q;
  logic [28:0] r2_q;
  logic signed [63:0] ntsq_q;
  logic signed [19:0] e_q, b_q, t_q;
  logic signed [15:0] cand_q [6];
  logic [ACC_W-1:0] acc_q [2];
  logic [2:0] k_q;
  logic moved_q, ok_q, first_q;
  logic out_valid_q, out_solved_q, out_retreated_q;

  logic [28:0] r2;
  logic too_far, too_near;
  logic signed [15:0] x_dec, y_dec;
  logic signed [31:0] num_e, num_t;
  logic signed [63:0] sq_val;
  logic [SQ_W-1:0] sq_in;
  logic sq_start, cor_start;
  logic [ROOT_W-1:0] root;
  pik_stat_t sq_stat, cor_stat;
  logic signed [ANG_W-1:0] cor_x, cor_y, cor_z;
  logic signed [MUL_W-1:0] mul_a, mul_b;
  logic signed [PROD_W-1:0] mul_p;
  logic [1:0] jnt;
  logic signed [15:0] st_sel;
  logic [7:0] w_sel;
  logic signed [16:0] diff;
  logic signed [19:0] s1, s2;

  function automatic logic signed [15:0] clamp_pos(input logic signed [15:0] v);
    logic signed [15:0] r;
    r = v;
    if (v < 16'(POS_MIN)) r = 16'(POS_MIN);
    if (v > 16'(POS_MAX)) r = 16'(POS_MAX);
    return r;
  endfunction

  function automatic logic signed [19:0] to_q13(input logic signed [ANG_W-1:0] a);
    logic signed [ANG_W-1:0] t;
    t = (a + 32'sd1024) >>> 11;
    return t[19:0];
  endfunction

  function automatic logic signed [15:0] sat16(input logic signed [19:0] v);
    logic signed [15:0] r;
    r = v[15:0];
    if (v > 20'sd32767)  r = 16'sh7fff;
    if (v < -20'sd32768) r = 16'sh8000;
    return r;
  endfunction

  always_comb begin
    r2       = {2'b00, xsq_q} + {2'b00, ysq_q};
    too_far  = r2 > 29'(REACH_FAR);
    too_near = r2 < 29'(REACH_NEAR);
    x_dec    = x_q - 16'(RETREAT_STEP);
    y_dec    = y_q - 16'(RETREAT_STEP);
    num_e    = $signed({3'b000, r2_q}) - L_SQ_SUM;
    num_t    = $signed({3'b000, r2_q}) + L_SQ_DIFF;
    sq_val   = (state_q == S_E1) ? DEN_E_SQ - $signed(mul_p[63:0])
                                 : $signed(mul_p[63:0]) - ntsq_q;
    sq_in    = (sq_val > 0) ? sq_val[SQ_W-1:0] : '0;
    sq_start = (state_q == S_E1) || (state_q == S_T2);
    cor_start = ((state_q == S_E2) && sq_stat.done) || ((state_q == S_E3) && cor_stat.done)
             || ((state_q == S_T3) && sq_stat.done);
    s1 = b_q + t_q;
    s2 = b_q - t_q;

    jnt = (k_q < 3'd3) ? k_q[1:0] : 2'(k_q - 3'd3);
    case (jnt)
      2'd0:    begin st_sel = shoulder_q; w_sel = w_sh_q; end
      2'd1:    begin st_sel = elbow_q;    w_sel = w_el_q; end
      default: begin st_sel = wrist_q;    w_sel = w_wr_q; end
    endcase
    diff = 17'(st_sel) - 17'(cand_q[k_q]);

    cor_x = '0;
    cor_y = '0;
    case (state_q)
      S_E2:    begin cor_x = num_e;        cor_y = ANG_W'({4'b0, root}); end
      S_E3:    begin cor_x = ANG_W'(x_q);  cor_y = ANG_W'(y_q); end
      S_T3:    begin cor_x = num_t;        cor_y = ANG_W'({4'b0, root}); end
      default: ;
    endcase

    mul_a = '0;
    mul_b = '0;
    case (state_q)
      S_SQX:   begin mul_a = MUL_W'(x_q);   mul_b = MUL_W'(x_q); end
      S_SQY:   begin mul_a = MUL_W'(y_q);   mul_b = MUL_W'(y_q); end
      S_E0:    begin mul_a = MUL_W'(num_e); mul_b = MUL_W'(num_e); end
      S_B0:    begin mul_a = MUL_W'(num_t); mul_b = MUL_W'(num_t); end
      S_T1:    begin
        mul_a = MUL_W'(FOUR_L1_SQ);
        mul_b = MUL_W'($signed({1'b0, r2_q}));
      end
      S_K_SQ:  begin mul_a = MUL_W'(diff);  mul_b = MUL_W'(diff); end
      S_K_WT:  begin
        mul_a = $signed(mul_p[MUL_W-1:0]);
        mul_b = MUL_W'($signed({1'b0, w_sel}));
      end
      default: ;
    endcase
  end

  pik_mul u_mul (
    .clk_i (clk_i),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (mul_p)
  );

  pik_isqrt u_isqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (sq_start),
    .v_i     (sq_in),
    .root_o  (root),
    .stat_o  (sq_stat)
  );

  pik_cordic u_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cor_start),
    .x_i     (cor_x),
    .y_i     (cor_y),
    .z_o     (cor_z),
    .stat_o  (cor_stat)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      w_sh_q <= 8'd154;
      w_el_q <= 8'd77;
      w_wr_q <= 8'd26;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_W_SHOULDER: w_sh_q <= cfg_data_i;
        REG_W_ELBOW:    w_el_q <= cfg_data_i;
        REG_W_WRIST:    w_wr_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q         <= S_IDLE;
      ph_q            <= PH_FIRST;
      shoulder_q      <= 16'sd17872;
      elbow_q         <= -16'sd17872;
      wrist_q         <= 16'sd0;
      yaw_st_q        <= 16'sd13583;
      out_valid_q     <= 1'b0;
      out_solved_q    <= 1'b0;
      out_retreated_q <= 1'b0;
      moved_q         <= 1'b0;
      ok_q            <= 1'b0;
      first_q         <= 1'b0;
      k_q             <= '0;
    end else begin
      // the finish state sets valid itself when the slot frees
      if (out_valid_q && out_ready_i && state_q != S_FIN) out_valid_q <= 1'b0;
      case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            x_q     <= clamp_pos(target_x_i);
            y_q     <= clamp_pos(target_y_i);
            yaw_q   <= target_yaw_i;
            moved_q <= 1'b0;
            ph_q    <= PH_FIRST;
            state_q <= S_SQX;
          end
        end
        S_SQX: state_q <= S_LDX;
        S_LDX: begin
          xsq_q   <= mul_p[26:0];
          state_q <= (ph_q == PH_XLOOP) ? S_CHK : S_SQY;
        end
        S_SQY: state_q <= S_LDY;
        S_LDY: begin
          ysq_q   <= mul_p[26:0];
          state_q <= S_CHK;
        end
        S_CHK: begin
          case (ph_q)
            PH_FIRST, PH_SECOND: begin
              if (too_far || too_near) begin
                if (ph_q == PH_FIRST) begin
                  ph_q <= PH_XLOOP;
                end else begin
                  ok_q    <= 1'b0;
                  state_q <= S_FIN;
                end
              end else begin
                r2_q    <= r2;
                state_q <= S_E0;
              end
            end
            PH_XLOOP: begin
              if (too_far) begin
                x_q     <= x_dec;
                moved_q <= 1'b1;
                if (x_dec <= 16'(X_FLOOR)) ph_q <= PH_YLOOP;
                state_q <= S_SQX;
              end else begin
                ph_q <= PH_YLOOP;
              end
            end
            default: begin
              if (too_far) begin
                y_q     <= y_dec;
                moved_q <= 1'b1;
                if (y_dec <= 16'(Y_FLOOR)) ph_q <= PH_SECOND;
                state_q <= S_SQY;
              end else begin
                ph_q <= PH_SECOND;
              end
            end
          endcase
        end
        S_E0: state_q <= S_E1;
        S_E1: state_q <= S_E2;
        S_E2: if (sq_stat.done) state_q <= S_E3;
        S_E3: begin
          if (cor_stat.done) begin
            e_q     <= to_q13(cor_z);
            state_q <= S_B0;
          end
        end
        S_B0: begin
          if (cor_stat.done) begin
            b_q     <= to_q13(cor_z);
            state_q <= S_T1;
          end
        end
        S_T1: begin
          ntsq_q  <= $signed(mul_p[63:0]);
          state_q <= S_T2;
        end
        S_T2: state_q <= S_T3;
        S_T3: if (sq_stat.done) state_q <= S_T4;
        S_T4: begin
          if (cor_stat.done) begin
            t_q     <= to_q13(cor_z);
            state_q <= S_C0;
          end
        end
        S_C0: begin
          // elbow-down first, elbow-up second
          cand_q[0] <= sat16(s1);
          cand_q[1] <= sat16(-e_q);
          cand_q[2] <= sat16(e_q - s1);
          cand_q[3] <= sat16(s2);
          cand_q[4] <= sat16(e_q);
          cand_q[5] <= sat16(-(s2 + e_q));
          acc_q[0]  <= '0;
          acc_q[1]  <= '0;
          k_q       <= '0;
          state_q   <= S_K_SQ;
        end
        S_K_SQ: state_q <= S_K_WT;
        S_K_WT: state_q <= S_K_ACC;
        S_K_ACC: begin
          if (k_q < 3'd3) acc_q[0] <= acc_q[0] + mul_p[ACC_W-1:0];
          else            acc_q[1] <= acc_q[1] + mul_p[ACC_W-1:0];
          k_q <= k_q + 3'd1;
          state_q <= (k_q == 3'd5) ? S_SEL : S_K_SQ;
        end
        S_SEL: begin
          // tie keeps the second solution
          first_q <= acc_q[0] < acc_q[1];
          ok_q    <= 1'b1;
          state_q <= S_FIN;
        end
        S_FIN: begin
          if (!out_valid_q || out_ready_i) begin
            if (ok_q) begin
              shoulder_q <= first_q ? cand_q[0] : cand_q[3];
              elbow_q    <= first_q ? cand_q[1] : cand_q[4];
              wrist_q    <= first_q ? cand_q[2] : cand_q[5];
              yaw_st_q   <= yaw_q;
            end
            out_valid_q     <= 1'b1;
            out_solved_q    <= ok_q;
            out_retreated_q <= moved_q;
            state_q         <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign in_ready_o     = (state_q == S_IDLE);
  assign out_valid_o    = out_valid_q;
  assign solved_o       = out_solved_q;
  assign retreated_o    = out_retreated_q;
  assign shoulder_out_o = shoulder_q;
  assign elbow_out_o    = elbow_q;
  assign wrist_out_o    = wrist_q;
  assign yaw_out_o      = yaw_st_q;

  a_cor_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cor_start |-> !cor_stat.busy) else $error("cordic started while busy");

  a_sq_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sq_start |-> !sq_stat.busy) else $error("root started while busy");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o) else $error("ready right after accept");

endmodule

@@ verif/tb_planar_arm_inverse_kinematics.sv @@
// testbench for the planar arm inverse kinematics block: predictor, scoreboard, stimulus
`timescale 1ns / 1ps
module tb_planar_arm_inverse_kinematics;
  import pik_pkg::*;

  localparam int RANDOM_TARGETS = 850;
  localparam int CYCLE_LIMIT    = 8000000;
  localparam logic [1:0] REG_UNMAPPED = 2'd3;

  typedef struct packed {
    logic               solved;
    logic               retreated;
    logic signed [15:0] shoulder;
    logic signed [15:0] elbow;
    logic signed [15:0] wrist;
    logic signed [15:0] yaw;
  } pose_t;

  class pose_scoreboard;
    pose_t   pending[$];
    int      mismatches;
    int      w_shoulder, w_elbow, w_wrist;
    longint  ang_shoulder, ang_elbow, ang_wrist, ang_yaw;

    function new();
      mismatches = 0;
      w_shoulder = 154; w_elbow = 77; w_wrist = 26;
      ang_shoulder = 17872; ang_elbow = -17872; ang_wrist = 0; ang_yaw = 13583;
    endfunction

    function void set_weight(logic [1:0] idx, logic [7:0] val);
      case (idx)
        REG_W_SHOULDER: w_shoulder = val;
        REG_W_ELBOW:    w_elbow    = val;
        REG_W_WRIST:    w_wrist    = val;
        default: ;
      endcase
    endfunction

    function longint unsigned root_floor(longint unsigned v);
      longint unsigned r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > v) b = b >> 2;
      while (b != 0) begin
        if (v >= r + b) begin
          v = v - (r + b);
          r = (r >> 1) + b;
        end else begin
          r = r >> 1;
        end
        b = b >> 2;
      end
      return r;
    endfunction

    function longint rot_angle(int i);
      case (i)
        0: return 13176795;
        1: return 7778716;
        2: return 4110060;
        3: return 2086331;
        4: return 1047214;
        5: return 524117;
        6: return 262123;
        7: return 131069;
        default: return (i <= 24) ? (64'sd1 <<< (24 - i)) : 64'sd0;
      endcase
    endfunction

    // vectoring cordic, angle in 2^-24 rad
    function longint vector_angle(longint y, longint x);
      longint ax, ay, cx, cy, nx, z;
      ax = (x < 0) ? -x : x;
      ay = (y < 0) ? -y : y;
      z = 0;
      if (ax == 0 && ay == 0) return 0;
      while (ax >= (64'sd1 <<< 30) || ay >= (64'sd1 <<< 30)) begin
        ax = ax >>> 1; ay = ay >>> 1;
      end
      while (ax < (64'sd1 <<< 29) && ay < (64'sd1 <<< 29)) begin
        ax = ax <<< 1; ay = ay <<< 1;
      end
      cx = ax; cy = ay;
      for (int i = 0; i < CORDIC_ITERS; i++) begin
        if (cy >= 0) begin
          nx = cx + (cy >>> i); cy = cy - (cx >>> i); z = z + rot_angle(i);
        end else begin
          nx = cx - (cy >>> i); cy = cy + (cx >>> i); z = z - rot_angle(i);
        end
        cx = nx;
      end
      if (x < 0) z = PI_Q24 - z;
      if (y < 0) z = -z;
      return z;
    endfunction

    function longint round_q13(longint a);
      return (a + 1024) >>> 11;
    endfunction

    function longint clip16(longint v);
      if (v > 32767) return 32767;
      if (v < -32768) return -32768;
      return v;
    endfunction

    function longint unsigned pose_cost(longint s, longint e, longint w);
      longint ds, de, dw;
      ds = ang_shoulder - s; de = ang_elbow - e; dw = ang_wrist - w;
      return longint'(ds * ds) * w_shoulder + longint'(de * de) * w_elbow
           + longint'(dw * dw) * w_wrist;
    endfunction

    function bit try_solve(longint x, longint y, longint yaw);
      longint l1, l2, r2, num_e, den_e, sq, e, b, t, num_t, s1, s2;
      longint cs1, ce1, cw1, cs2, ce2, cw2;
      longint unsigned sin_e, sin_t;
      l1 = LINK_ONE_LEN; l2 = LINK_TWO_LEN;
      r2 = x * x + y * y;
      if (r2 > (l1 + l2) * (l1 + l2) || r2 < (l1 - l2) * (l1 - l2)) return 0;
      num_e = r2 - l1 * l1 - l2 * l2;
      den_e = 2 * l1 * l2;
      sq = den_e * den_e - num_e * num_e;
      sin_e = (sq > 0) ? root_floor(sq) : 0;
      e = round_q13(vector_angle(longint'(sin_e), num_e));
      b = round_q13(vector_angle(y, x));
      num_t = r2 + l1 * l1 - l2 * l2;
      sq = 4 * l1 * l1 * r2 - num_t * num_t;   // clamp cos rounding overflow
      sin_t = (sq > 0) ? root_floor(sq) : 0;
      t = round_q13(vector_angle(longint'(sin_t), num_t));
      s1 = b + t; s2 = b - t;
      cs1 = clip16(s1); ce1 = clip16(-e); cw1 = clip16(-(s1 - e));
      cs2 = clip16(s2); ce2 = clip16(e);  cw2 = clip16(-(s2 + e));
      if (pose_cost(cs1, ce1, cw1) < pose_cost(cs2, ce2, cw2)) begin
        ang_shoulder = cs1; ang_elbow = ce1; ang_wrist = cw1;
      end else begin
        ang_shoulder = cs2; ang_elbow = ce2; ang_wrist = cw2;
      end
      ang_yaw = yaw;
      return 1;
    endfunction

    function void note_target(logic signed [15:0] tx, logic signed [15:0] ty,
                              logic signed [15:0] tyaw);
      longint x, y, far_sq;
      bit     ok, moved;
      pose_t  p;
      far_sq = longint'(LINK_ONE_LEN + LINK_TWO_LEN) * (LINK_ONE_LEN + LINK_TWO_LEN);
      x = tx; y = ty; moved = 0;
      if (x < POS_MIN) x = POS_MIN;
      if (x > POS_MAX) x = POS_MAX;
      if (y < POS_MIN) y = POS_MIN;
      if (y > POS_MAX) y = POS_MAX;
      ok = try_solve(x, y, tyaw);
      if (!ok) begin
        while (x * x + y * y > far_sq) begin
          x = x - RETREAT_STEP; moved = 1;
          if (x <= X_FLOOR) break;
        end
        while (x * x + y * y > far_sq) begin
          y = y - RETREAT_STEP; moved = 1;
          if (y <= Y_FLOOR) break;
        end
        ok = try_solve(x, y, tyaw);
      end
      p.solved = ok; p.retreated = moved;
      p.shoulder = ang_shoulder[15:0]; p.elbow = ang_elbow[15:0];
      p.wrist = ang_wrist[15:0]; p.yaw = ang_yaw[15:0];
      pending.push_back(p);
    endfunction

    function void check_pose(pose_t got);
      pose_t exp_p;
      if (pending.size() == 0) begin
        $error("result transaction with no target outstanding");
        mismatches++;
        return;
      end
      exp_p = pending.pop_front();
      if (got.solved !== exp_p.solved) begin
        $error("solved: expected %0d actual %0d", exp_p.solved, got.solved); mismatches++;
      end
      if (got.retreated !== exp_p.retreated) begin
        $error("retreated: expected %0d actual %0d", exp_p.retreated, got.retreated);
        mismatches++;
      end
      if (got.shoulder !== exp_p.shoulder) begin
        $error("shoulder_out: expected %0d actual %0d", exp_p.shoulder, got.shoulder);
        mismatches++;
      end
      if (got.elbow !== exp_p.elbow) begin
        $error("elbow_out: expected %0d actual %0d", exp_p.elbow, got.elbow); mismatches++;
      end
      if (got.wrist !== exp_p.wrist) begin
        $error("wrist_out: expected %0d actual %0d", exp_p.wrist, got.wrist); mismatches++;
      end
      if (got.yaw !== exp_p.yaw) begin
        $error("yaw_out: expected %0d actual %0d", exp_p.yaw, got.yaw); mismatches++;
      end
    endfunction
  endclass

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               cfg_we_i = 1'b0;
  logic [1:0]         cfg_idx_i = '0;
  logic [7:0]         cfg_data_i = '0;
  logic               in_valid_i = 1'b0;
  logic               in_ready_o;
  logic signed [15:0] target_x_i = '0;
  logic signed [15:0] target_y_i = '0;
  logic signed [15:0] target_yaw_i = '0;
  logic               out_valid_o;
  logic               out_ready_i = 1'b0;
  logic               solved_o, retreated_o;
  logic signed [15:0] shoulder_out_o, elbow_out_o, wrist_out_o, yaw_out_o;

  pose_scoreboard pose_sb = new();
  int unsigned    cycle_count = 0;

  planar_arm_inverse_kinematics i_dut (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 92) return $urandom_range(1, 4);
    return $urandom_range(20, 300);
  endfunction

  // monitors sample pre-edge values
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
    if (rst_ni && in_valid_i && in_ready_o)
      pose_sb.note_target(target_x_i, target_y_i, target_yaw_i);
    if (rst_ni && out_valid_o && out_ready_i)
      pose_sb.check_pose({solved_o, retreated_o, shoulder_out_o, elbow_out_o,
                          wrist_out_o, yaw_out_o});
  end

  initial begin : result_stall
    int n;
    @(posedge rst_ni);
    forever begin
      n = $urandom_range(1, 40);
      out_ready_i <= 1'b1;
      repeat (n) @(posedge clk_i);
      n = pick_gap();
      if (n > 0) begin
        out_ready_i <= 1'b0;
        repeat (n) @(posedge clk_i);
      end
    end
  end

  task automatic send_target(logic signed [15:0] x, logic signed [15:0] y,
                             logic signed [15:0] yaw);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    target_x_i   <= x;
    target_y_i   <= y;
    target_yaw_i <= yaw;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pose_sb.pending.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_weight(logic [1:0] idx, logic [7:0] val);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    pose_sb.set_weight(idx, val);
  endtask

  task automatic write_weights(logic [7:0] ws, logic [7:0] we, logic [7:0] ww);
    write_weight(REG_W_SHOULDER, ws);
    write_weight(REG_W_ELBOW, we);
    write_weight(REG_W_WRIST, ww);
    write_weight(REG_UNMAPPED, 8'($urandom));   // unmapped index, must be ignored
  endtask

  task automatic send_random_target();
    logic signed [15:0] x, y;
    if ($urandom_range(0, 9) < 8) begin
      x = 16'($urandom_range(1800, 11000));
      y = 16'($urandom_range(1800, 11000));
    end else begin
      x = 16'($urandom);
      y = 16'($urandom);
    end
    send_target(x, y, 16'($urandom));
  endtask

  initial begin : stimulus
    logic [7:0] phase_w[6][3];
    phase_w = '{'{8'd0, 8'd0, 8'd0}, '{8'd255, 8'd255, 8'd255}, '{8'd255, 8'd0, 8'd0},
                '{8'd0, 8'd0, 8'd255}, '{8'd1, 8'd255, 8'd0}, '{8'd0, 8'd0, 8'd0}};
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: field extremes, clamp edges, far retreat, reach boundary
    send_target(16'sh8000, 16'sh8000, 16'sh8000);
    send_target(16'sh7fff, 16'sh7fff, 16'sh7fff);
    send_target(16'sh0000, 16'sh0000, 16'sh0000);
    send_target(16'shffff, 16'sh7fff, 16'shffff);
    send_target(16'sh7fff, 16'sh8000, 16'sh5555);
    send_target(16'(POS_MIN), 16'(POS_MIN), 16'shaaaa);
    send_target(16'(POS_MAX), 16'(POS_MAX), 16'sh1234);
    send_target(16'(POS_MAX), 16'(POS_MIN), 16'sh0001);
    send_target(16'(POS_MIN), 16'(POS_MAX), -16'sd1);
    send_target(16'sd11555, 16'(POS_MIN), 16'sd100);
    send_target(16'(POS_MIN), 16'sd11555, 16'sd200);
    send_target(16'sd8170, 16'sd8170, 16'sd300);
    send_target(16'sd8171, 16'sd8171, 16'sd400);
    send_target(16'sd6000, 16'sd5000, 16'sd500);
    drain();
    write_weights(8'd0, 8'd0, 8'd0);   // equal costs pick the second solution
    send_target(16'sd6000, 16'sd5000, 16'sd0);
    send_target(16'sd3000, 16'sd9000, 16'sd0);
    send_target(16'(POS_MIN), 16'(POS_MAX), 16'sd0);
    send_target(16'(POS_MAX), 16'(POS_MAX), 16'sd0);
    drain();
    write_weights(8'd154, 8'd77, 8'd26);

    for (int p = 0; p < 7; p++) begin
      for (int k = 0; k < RANDOM_TARGETS / 7 + 1; k++) send_random_target();
      drain();
      if (p < 6) write_weights(phase_w[p][0], phase_w[p][1], phase_w[p][2]);
      else write_weights(8'($urandom), 8'($urandom), 8'($urandom));
    end
    for (int k = 0; k < 20; k++) send_random_target();
    drain();
    repeat (2000) @(posedge clk_i);

    if (pose_sb.mismatches == 0 && pose_sb.pending.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
